### hdl/dbd_pkg.sv
package dbd_pkg;

  // Field widths
  localparam int unsigned DayW   = 5;
  localparam int unsigned MonthW = 4;
  localparam int unsigned YearW  = 14;
  localparam int unsigned DiffW  = 23;

  // Day number of a date: at most 16383*365 + 4096 + 366, fits 23 bits
  localparam int unsigned DayNumW = 23;

  localparam int unsigned DaysPerYear = 365;

  typedef logic [DayW-1:0]    day_t;
  typedef logic [MonthW-1:0]  month_t;
  typedef logic [YearW-1:0]   year_t;
  typedef logic [DayNumW-1:0] day_num_t;
  typedef logic signed [DiffW-1:0] diff_t;
  // One extra bit so the raw difference never wraps before saturation
  typedef logic signed [DayNumW:0] wide_diff_t;

  localparam diff_t DiffMax = {1'b0, {(DiffW-1){1'b1}}};
  localparam diff_t DiffMin = {1'b1, {(DiffW-1){1'b0}}};

  // Days in a common year before the first of the month; month zero counts
  // as January and months past twelve count as December
  function automatic logic [8:0] days_before_month(input month_t month);
    logic [8:0] days;
    case (month) inside
      4'd0, 4'd1: days = 9'd0;
      4'd2:       days = 9'd31;
      4'd3:       days = 9'd59;
      4'd4:       days = 9'd90;
      4'd5:       days = 9'd120;
      4'd6:       days = 9'd151;
      4'd7:       days = 9'd181;
      4'd8:       days = 9'd212;
      4'd9:       days = 9'd243;
      4'd10:      days = 9'd273;
      4'd11:      days = 9'd304;
      [4'd12:4'd15]: days = 9'd334;
      default:    days = 9'd0;
    endcase
    return days;
  endfunction

endpackage

### hdl/dbd_in_if.sv
interface dbd_in_if;
  logic                valid;
  logic                ready;
  dbd_pkg::day_t       first_day;
  dbd_pkg::month_t     first_month;
  dbd_pkg::year_t      first_year;
  dbd_pkg::day_t       second_day;
  dbd_pkg::month_t     second_month;
  dbd_pkg::year_t      second_year;

  modport source (
    output valid, first_day, first_month, first_year,
    output second_day, second_month, second_year,
    input  ready
  );

  modport sink (
    input  valid, first_day, first_month, first_year,
    input  second_day, second_month, second_year,
    output ready
  );
endinterface

### hdl/dbd_out_if.sv
interface dbd_out_if;
  logic                valid;
  logic                ready;
  dbd_pkg::diff_t      day_difference;

  modport source (
    output valid, day_difference,
    input  ready
  );

  modport sink (
    input  valid, day_difference,
    output ready
  );
endinterface

### hdl/dbd_day_number.sv
// Day number of one date: years before it, leap days before it,
// days of earlier months, and the day of month.
module dbd_day_number (
  input  dbd_pkg::day_t     day,
  input  dbd_pkg::month_t   month,
  input  dbd_pkg::year_t    year,
  output dbd_pkg::day_num_t day_num
);

  logic                         leap_adj;
  logic [dbd_pkg::YearW-2:0]    leap_days;
  logic [dbd_pkg::YearW:0]      year_plus3;
  dbd_pkg::day_num_t            year_days;
  logic [9:0]                   in_year;

  // Leap years are those divisible by four; count them before this year
  assign year_plus3 = {1'b0, year} + (dbd_pkg::YearW+1)'(3);
  assign leap_days  = year_plus3[dbd_pkg::YearW:2];

  // Constant multiply, shift-add after synthesis
  assign year_days = dbd_pkg::day_num_t'(year)
                   * dbd_pkg::day_num_t'(dbd_pkg::DaysPerYear);

  // February 29 lies before every month after February in a leap year
  assign leap_adj = (year[1:0] == 2'b00) && (month > 4'd2);

  assign in_year = {1'b0, dbd_pkg::days_before_month(month)}
                 + 10'(leap_adj) + 10'(day);

  assign day_num = year_days + dbd_pkg::day_num_t'(leap_days)
                 + dbd_pkg::day_num_t'(in_year);

endmodule

### hdl/days_between_dates.sv
// An accepted item passes the input register, then the result register.
// Throughput: one item per cycle; the only stall is backpressure on result.
// Reset (rst, synchronous, active high) empties both registers; nothing else
// holds state.
module days_between_dates (
  input  logic            clk,
  input  logic            rst,
  dbd_in_if.sink          dates,
  dbd_out_if.source       result
);

  // Input register
  logic              in_valid;
  dbd_pkg::day_t     r_first_day;
  dbd_pkg::month_t   r_first_month;
  dbd_pkg::year_t    r_first_year;
  dbd_pkg::day_t     r_second_day;
  dbd_pkg::month_t   r_second_month;
  dbd_pkg::year_t    r_second_year;

  logic              out_adv;
  logic              in_adv;

  dbd_pkg::day_num_t  first_num;
  dbd_pkg::day_num_t  second_num;
  dbd_pkg::wide_diff_t raw_diff;
  dbd_pkg::diff_t     diff_next;

  // Pipeline flow: result register frees when empty or taken
  assign out_adv     = !result.valid || result.ready;
  assign in_adv      = !in_valid || out_adv;
  assign dates.ready = in_adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (in_adv) begin
      in_valid <= dates.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_adv && dates.valid) begin
      r_first_day    <= dates.first_day;
      r_first_month  <= dates.first_month;
      r_first_year   <= dates.first_year;
      r_second_day   <= dates.second_day;
      r_second_month <= dates.second_month;
      r_second_year  <= dates.second_year;
    end
  end

  // Day numbers of both dates
  dbd_day_number u_first (
    .day     (r_first_day),
    .month   (r_first_month),
    .year    (r_first_year),
    .day_num (first_num)
  );

  dbd_day_number u_second (
    .day     (r_second_day),
    .month   (r_second_month),
    .year    (r_second_year),
    .day_num (second_num)
  );

  // Difference, saturated to the result field
  assign raw_diff = $signed({1'b0, second_num}) - $signed({1'b0, first_num});

  always_comb begin
    if (raw_diff > dbd_pkg::wide_diff_t'(dbd_pkg::DiffMax)) begin
      diff_next = dbd_pkg::DiffMax;
    end else if (raw_diff < dbd_pkg::wide_diff_t'(dbd_pkg::DiffMin)) begin
      diff_next = dbd_pkg::DiffMin;
    end else begin
      diff_next = raw_diff[dbd_pkg::DiffW-1:0];
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      result.valid <= 1'b0;
    end else if (out_adv) begin
      result.valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (out_adv && in_valid) begin
      result.day_difference <= diff_next;
    end
  end

  // Checks
  a_reset_empty: assert property (@(posedge clk) $past(rst) |-> !result.valid && !in_valid)
    else $error("pipeline not empty after reset");

  a_accept_loads: assert property (@(posedge clk) disable iff (rst)
    dates.valid && dates.ready |=> in_valid)
    else $error("accepted item lost at input register");

  a_stage_moves: assert property (@(posedge clk) disable iff (rst)
    in_valid && out_adv |=> result.valid)
    else $error("item lost between input and result registers");

  a_stall_holds: assert property (@(posedge clk) disable iff (rst)
    in_valid && !out_adv |=> in_valid && $stable(r_first_year) && $stable(r_second_year))
    else $error("stalled item in input register changed");

  a_drain: assert property (@(posedge clk) disable iff (rst)
    result.valid && result.ready && !in_valid |=> !result.valid)
    else $error("result repeated after it was taken");

endmodule

### tb/sv/tb_top.sv
module tb_top;

  // One input item: both dates, in port order
  typedef struct packed {
    dbd_pkg::day_t   first_day;
    dbd_pkg::month_t first_month;
    dbd_pkg::year_t  first_year;
    dbd_pkg::day_t   second_day;
    dbd_pkg::month_t second_month;
    dbd_pkg::year_t  second_year;
  } date_pair_t;

  logic clk = 1'b0;
  logic rst;

  dbd_in_if  dates_if ();
  dbd_out_if result_if ();

  days_between_dates u_dut (
    .clk    (clk),
    .rst    (rst),
    .dates  (dates_if),
    .result (result_if)
  );

  always #5 clk = ~clk;

  dbd_pkg::diff_t diffs_due[$];
  dbd_pkg::diff_t want_diff;
  int unsigned    error_count = 0;
  bit             idle_en = 1'b0;

  // Cumulative days of a common year before the given month, month clamped to 1..12
  function automatic int unsigned days_ahead_of_month(input dbd_pkg::month_t month);
    int unsigned m;
    m = (month < 1) ? 1 : (month > 12) ? 12 : month;
    case (m)
      1:       return 0;
      2:       return 31;
      3:       return 59;
      4:       return 90;
      5:       return 120;
      6:       return 151;
      7:       return 181;
      8:       return 212;
      9:       return 243;
      10:      return 273;
      11:      return 304;
      default: return 334;
    endcase
  endfunction

  // Day count since year zero; every year divisible by four is a leap year
  function automatic longint date_ordinal(input dbd_pkg::day_t day,
                                          input dbd_pkg::month_t month,
                                          input dbd_pkg::year_t year);
    longint ordinal;
    ordinal = longint'(year) * 365 + (longint'(year) + 3) / 4;
    ordinal += days_ahead_of_month(month) + day;
    if (year % 4 == 0 && month > 2)
      ordinal += 1;
    return ordinal;
  endfunction

  // Second date minus first, saturated to the result width
  function automatic dbd_pkg::diff_t predict_day_difference(input date_pair_t p);
    longint span;
    span = date_ordinal(p.second_day, p.second_month, p.second_year)
         - date_ordinal(p.first_day, p.first_month, p.first_year);
    if (span > longint'(dbd_pkg::DiffMax))
      span = longint'(dbd_pkg::DiffMax);
    if (span < longint'(dbd_pkg::DiffMin))
      span = longint'(dbd_pkg::DiffMin);
    return dbd_pkg::diff_t'(span);
  endfunction

  function automatic date_pair_t make_pair(input int d1, input int m1, input int y1,
                                           input int d2, input int m2, input int y2);
    date_pair_t p;
    p.first_day    = dbd_pkg::day_t'(d1);
    p.first_month  = dbd_pkg::month_t'(m1);
    p.first_year   = dbd_pkg::year_t'(y1);
    p.second_day   = dbd_pkg::day_t'(d2);
    p.second_month = dbd_pkg::month_t'(m2);
    p.second_year  = dbd_pkg::year_t'(y2);
    return p;
  endfunction

  function automatic int corner_year();
    case ($urandom_range(0, 7))
      0:       return 0;
      1:       return 3;
      2:       return 4;
      3:       return 1000;
      4:       return 9999;
      5:       return 16380;
      6:       return 16383;
      default: return $urandom_range(0, 16383);
    endcase
  endfunction

  function automatic int corner_month();
    case ($urandom_range(0, 6))
      0:       return 0;
      1:       return 1;
      2:       return 2;
      3:       return 3;
      4:       return 12;
      5:       return 13;
      default: return 15;
    endcase
  endfunction

  function automatic int corner_day();
    case ($urandom_range(0, 5))
      0:       return 0;
      1:       return 1;
      2:       return 28;
      3:       return 29;
      4:       return 30;
      default: return 31;
    endcase
  endfunction

  // Mostly valid calendar dates, some close pairs, raw bit patterns and corners
  function automatic date_pair_t random_pair();
    date_pair_t  p;
    logic [63:0] bits;
    int unsigned kind;
    int          y1;
    kind = $urandom_range(0, 99);
    if (kind < 60) begin
      p = make_pair($urandom_range(1, 31), $urandom_range(1, 12), $urandom_range(1000, 9999),
                    $urandom_range(1, 31), $urandom_range(1, 12), $urandom_range(1000, 9999));
    end else if (kind < 75) begin
      y1 = $urandom_range(1002, 9997);
      p = make_pair($urandom_range(1, 31), $urandom_range(1, 12), y1,
                    $urandom_range(1, 31), $urandom_range(1, 12),
                    y1 + $urandom_range(0, 4) - 2);
    end else if (kind < 90) begin
      bits = {$urandom, $urandom};
      p = bits[$bits(date_pair_t)-1:0];
    end else begin
      p = make_pair(corner_day(), corner_month(), corner_year(),
                    corner_day(), corner_month(), corner_year());
    end
    return p;
  endfunction

  // Drive one item, optionally after an idle burst, and log its expected result
  task automatic send_dates(input date_pair_t p);
    if (idle_en && $urandom_range(0, 4) == 0) begin
      dates_if.valid <= 1'b0;
      repeat ($urandom_range(1, 17)) @(posedge clk);
    end
    dates_if.valid        <= 1'b1;
    dates_if.first_day    <= p.first_day;
    dates_if.first_month  <= p.first_month;
    dates_if.first_year   <= p.first_year;
    dates_if.second_day   <= p.second_day;
    dates_if.second_month <= p.second_month;
    dates_if.second_year  <= p.second_year;
    do @(posedge clk); while (!dates_if.ready);
    diffs_due.push_back(predict_day_difference(p));
  endtask

  // Ordinary calendar spans, leap handling and order reversal
  task automatic test_calendar_spans();
    idle_en = 1'b0;
    send_dates(make_pair(1, 1, 1000, 1, 1, 1000));
    send_dates(make_pair(1, 1, 1000, 31, 12, 9999));
    send_dates(make_pair(31, 12, 9999, 1, 1, 1000));
    send_dates(make_pair(28, 2, 2024, 1, 3, 2024));
    send_dates(make_pair(28, 2, 2023, 1, 3, 2023));
    send_dates(make_pair(29, 2, 2024, 1, 3, 2024));
    send_dates(make_pair(28, 2, 1900, 1, 3, 1900));
    send_dates(make_pair(31, 12, 1999, 1, 1, 2000));
    send_dates(make_pair(1, 1, 2001, 1, 1, 2000));
    send_dates(make_pair(15, 6, 2020, 15, 6, 2021));
    send_dates(make_pair(1, 3, 2000, 1, 3, 2004));
  endtask

  // Out-of-range days and months, extreme years, saturation, all-zero and all-one fields
  task automatic test_open_cases();
    idle_en = 1'b1;
    send_dates(make_pair(0, 5, 2000, 1, 5, 2000));
    send_dates(make_pair(31, 2, 2001, 1, 3, 2001));
    send_dates(make_pair(15, 0, 2000, 15, 1, 2000));
    send_dates(make_pair(1, 12, 2000, 1, 13, 2000));
    send_dates(make_pair(1, 15, 2003, 1, 12, 2003));
    send_dates(make_pair(1, 1, 0, 31, 12, 16383));
    send_dates(make_pair(31, 12, 16383, 1, 1, 0));
    send_dates(make_pair(0, 0, 0, 31, 15, 16383));
    send_dates(make_pair(31, 15, 16383, 0, 0, 0));
    send_dates(make_pair(0, 0, 0, 0, 0, 0));
    send_dates(make_pair(31, 15, 16383, 31, 15, 16383));
    send_dates(make_pair(1, 3, 16380, 1, 2, 16380));
    send_dates(make_pair(1, 1, 3, 1, 1, 4));
  endtask

  // Random items; idling switches on and off in stretches
  task automatic test_random_dates(input int count);
    for (int i = 0; i < count; i++) begin
      if (i % 150 == 0)
        idle_en = ($urandom_range(0, 3) != 0);
      send_dates(random_pair());
    end
  endtask

  // Closing stretch at full rate on both sides
  task automatic test_back_to_back(input int count);
    idle_en = 1'b0;
    for (int i = 0; i < count; i++)
      send_dates(random_pair());
  endtask

  // Stimulus sequence
  initial begin
    rst                   <= 1'b1;
    dates_if.valid        <= 1'b0;
    dates_if.first_day    <= '0;
    dates_if.first_month  <= '0;
    dates_if.first_year   <= '0;
    dates_if.second_day   <= '0;
    dates_if.second_month <= '0;
    dates_if.second_year  <= '0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_calendar_spans();
    test_open_cases();
    test_random_dates(1600);
    test_back_to_back(200);
    dates_if.valid <= 1'b0;

    while (diffs_due.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (error_count == 0)
      $display("status: pass");
    else
      $display("status: fail");
    $finish;
  end

  // Result backpressure: random stall bursts while idling is on
  initial begin
    result_if.ready <= 1'b0;
    do @(posedge clk); while (rst);
    result_if.ready <= 1'b1;
    forever begin
      @(posedge clk);
      if (idle_en && $urandom_range(0, 5) == 0) begin
        result_if.ready <= 1'b0;
        repeat ($urandom_range(1, 17)) @(posedge clk);
      end
      result_if.ready <= 1'b1;
    end
  end

  // Compare each accepted result with the oldest expected difference
  always @(posedge clk) begin
    if (!rst && result_if.valid && result_if.ready) begin
      if (diffs_due.size() == 0) begin
        error_count++;
        $display("%0t: unexpected result, expected none, actual %0d",
                 $time, result_if.day_difference);
      end else begin
        want_diff = diffs_due.pop_front();
        if (result_if.day_difference !== want_diff) begin
          error_count++;
          $display("%0t: day_difference mismatch, expected %0d, actual %0d",
                   $time, want_diff, result_if.day_difference);
        end
      end
    end
  end

  // Watchdog
  initial begin
    #5_000_000;
    $display("status: fail");
    $finish;
  end

endmodule
